// ===== hw/rtl/rbb_pkg.sv =====
`default_nettype none

package rbb_pkg;

   localparam int CHAN_W      = 8;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // 3x3 window: columns left/center/right, rows top/middle/bottom
   localparam int TAP_COLS = 3;
   localparam int TAP_ROWS = 3;

   // nine 8-bit terms fit in 12 bits (max 2295)
   localparam int SUM_W = 12;

   // floor(x / 9) = (x * 7282) >> 16, exact for x <= 2295
   localparam int               DIV9_SHIFT = 16;
   localparam int               DIV9_MUL_W = 13;
   localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_FLUSH = 1'b1
   } kind_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // one line buffer entry: the two rows above the incoming pixel
   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_type;

   typedef logic [TAP_COLS-1:0][TAP_ROWS-1:0][CHAN_W-1:0] lane_taps_type;

   typedef struct packed {
      logic valid;
      logic frame_end;
   } ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rbb_if.sv =====
`default_nettype none

interface rbb_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [rbb_pkg::CHAN_W-1:0]  red_in;
   logic [rbb_pkg::CHAN_W-1:0]  green_in;
   logic [rbb_pkg::CHAN_W-1:0]  blue_in;

   modport source (output valid, kind, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface rbb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rbb_pkg::CHAN_W-1:0]  red_out;
   logic [rbb_pkg::CHAN_W-1:0]  green_out;
   logic [rbb_pkg::CHAN_W-1:0]  blue_out;
   logic                        frame_end;

   modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rbb_line_buf.sv =====
`default_nettype none

module rbb_line_buf #(
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic               clock,
   input  wire logic               rd_en,
   input  wire logic [AW-1:0]      rd_addr,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire rbb_pkg::line_type  wr_data,
   output rbb_pkg::line_type       rd_data
);

   localparam int LINE_W = $bits(rbb_pkg::line_type);

   logic [LINE_W-1:0]  line_mem [DEPTH];
   logic [LINE_W-1:0]  rd_q_ff;
   logic [AW-1:0]      rd_addr_ff;
   logic [AW-1:0]      last_addr_ff;
   rbb_pkg::line_type  last_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
         last_addr_ff      <= wr_addr;
         last_data_ff      <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff    <= line_mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // read-first RAM: a read issued in the cycle of a write to the same
   // entry (one-pixel rows) takes the newest data from the last write
   assign rd_data = (rd_addr_ff == last_addr_ff) ? last_data_ff
                                                 : rbb_pkg::line_type'(rd_q_ff);

endmodule

`default_nettype wire

// ===== hw/rtl/rbb_lane.sv =====
`default_nettype none

module rbb_lane (
   input  wire logic                        clock,
   input  wire logic                        load,
   input  wire rbb_pkg::lane_taps_type      taps,
   output logic [rbb_pkg::CHAN_W-1:0]       quotient
);

   localparam int COL_SUM_W = 10;
   localparam int PROD_W    = rbb_pkg::DIV9_SHIFT + rbb_pkg::CHAN_W;

   logic [COL_SUM_W-1:0]       col_sum [rbb_pkg::TAP_COLS];
   logic [rbb_pkg::SUM_W-1:0]  sum_in;
   logic [rbb_pkg::SUM_W-1:0]  sum_ff;
   logic [PROD_W-1:0]          product;

   always_comb begin
      for (int i = 0; i < rbb_pkg::TAP_COLS; i++) begin
         col_sum[i] = COL_SUM_W'(taps[i][0]) + COL_SUM_W'(taps[i][1])
                    + COL_SUM_W'(taps[i][2]);
      end
   end

   assign sum_in = rbb_pkg::SUM_W'(col_sum[0]) + rbb_pkg::SUM_W'(col_sum[1])
                 + rbb_pkg::SUM_W'(col_sum[2]);

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
      end
   end

   // divide by 9: reciprocal multiply, product stays below 2^24
   assign product  = PROD_W'(sum_ff) * PROD_W'(rbb_pkg::DIV9_MUL);
   assign quotient = product[rbb_pkg::DIV9_SHIFT +: rbb_pkg::CHAN_W];

endmodule

`default_nettype wire

// ===== hw/rtl/rbb_merge.sv =====
`default_nettype none

module rbb_merge (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rbb_pkg::ctl_type    ctl,
   input  wire rbb_pkg::pixel_type  avg,
   output logic                     take,
   rbb_rsp_if.source                rsp_bus
);

   logic               out_valid_ff;
   logic               out_valid_in;
   rbb_pkg::pixel_type avg_ff;
   logic               frame_end_ff;

   assign take         = !out_valid_ff || rsp_bus.ready;
   assign out_valid_in = take ? ctl.valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && ctl.valid) begin
         avg_ff       <= avg;
         frame_end_ff <= ctl.frame_end;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.red_out   = avg_ff.red;
   assign rsp_bus.green_out = avg_ff.green;
   assign rsp_bus.blue_out  = avg_ff.blue;
   assign rsp_bus.frame_end = frame_end_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_box_blur_3x3_top.sv =====
`default_nettype none

// Streaming 3x3 box blur on 24-bit RGB pixels. Pixels come in raster order,
// one req beat each (kind = pixel); each rsp beat carries, per channel, the
// floor of the sum of the 3x3 neighborhood divided by 9, with neighbors
// outside the image counted as zero. Results trail the input by
// image_width+1 pixels, so after the frame's last pixel the host sends
// image_width+1 flush beats (kind = flush) to drain them; the rsp beat of
// the frame's last pixel has frame_end set, and the next pixel opens a new
// frame. A flush beat before the last pixel is taken and dropped; a pixel
// beat after it counts as a flush. Throughput is one beat per clock while
// rsp beats are taken, for any frame size: the line buffer is a single RAM
// of MAX_WIDTH entries holding the two previous rows, read and written once
// per pixel. From the req beat that completes a neighborhood to the rsp
// beat the data passes four registered stages (RAM read, window/mask, lane
// adder tree, divide-by-9 into the output register); the block keeps taking
// req beats while an rsp beat waits, until all four are full. There is no
// clearing pass after reset: stale RAM and window contents are always
// masked off at the frame borders. CSR writes (index 0 image_width, index 1
// image_height; zero reads as 1, values above MAX_WIDTH / MAX_HEIGHT are
// clamped) restart the frame and are to be made only while the block is idle.

module rgb_box_blur_3x3_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   rbb_req_if.sink                                req_bus,
   rbb_rsp_if.source                              rsp_bus,
   input  wire logic                              csr_we,
   input  wire logic [rbb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [rbb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int WDIM_W       = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W        = $clog2(MAX_HEIGHT + 2);   // row runs to height+1
   localparam int RESET_WIDTH  = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
   localparam int RESET_HEIGHT = (MAX_HEIGHT < 480) ? MAX_HEIGHT : 480;
   localparam int NCOL         = rbb_pkg::TAP_COLS;
   localparam int NROW         = rbb_pkg::TAP_ROWS;

   function automatic logic [WDIM_W-1:0] clamp_width(
      input logic [rbb_pkg::CSR_DATA_W-1:0] v
   );
      int unsigned x;
      x = 32'(v);
      if (x == 0) begin
         x = 1;
      end else if (x > MAX_WIDTH) begin
         x = MAX_WIDTH;
      end
      return WDIM_W'(x);
   endfunction

   function automatic logic [ROW_W-1:0] clamp_height(
      input logic [rbb_pkg::CSR_DATA_W-1:0] v
   );
      int unsigned x;
      x = 32'(v);
      if (x == 0) begin
         x = 1;
      end else if (x > MAX_HEIGHT) begin
         x = MAX_HEIGHT;
      end
      return ROW_W'(x);
   endfunction

   // ---------------------------------------------------------------
   // Geometry registers (stored already clamped)
   // ---------------------------------------------------------------
   logic [WDIM_W-1:0] width_ff,  width_in;
   logic [ROW_W-1:0]  height_ff, height_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we && csr_index == rbb_pkg::CSR_IMAGE_WIDTH) begin
         width_in = clamp_width(csr_wdata);
      end
      if (csr_we && csr_index == rbb_pkg::CSR_IMAGE_HEIGHT) begin
         height_in = clamp_height(csr_wdata);
      end
   end

   // ---------------------------------------------------------------
   // Pipeline handshake: a stage moves when the next one is empty or
   // moving; bubbles collapse, so req stays open behind a stalled rsp.
   // ---------------------------------------------------------------
   logic             v1_ff, v1_in;
   logic             v2_ff, v2_in;
   rbb_pkg::ctl_type ctl3_ff, ctl3_in;
   logic             en1, en2, en3, take4;

   assign en3 = !ctl3_ff.valid || take4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_bus.ready = en1;

   // ---------------------------------------------------------------
   // Stage 1: position tracking and border decisions for the new beat
   // ---------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic accept, is_flush, real_px, load1;
   logic emit, row_start, mid_row;
   logic top_ok, bot_ok, left_ok, frame_end, col_last;
   rbb_pkg::pixel_type pix_in;

   assign accept   = req_bus.valid && req_bus.ready;
   assign is_flush = req_bus.kind == rbb_pkg::KIND_FLUSH;
   assign real_px  = row_ff < height_ff;
   // a flush before the frame's last pixel is swallowed
   assign load1    = accept && !(is_flush && real_px);

   // a result is due once width+1 beats of the frame are in
   assign emit      = (row_ff >= ROW_W'(2)) || (row_ff == ROW_W'(1) && col_ff != '0);
   // row start closes the previous row's last pixel (no right neighbor);
   // mid-row produces the pixel one row up and one column left
   assign row_start = emit && col_ff == '0;
   assign mid_row   = emit && col_ff != '0;

   assign top_ok  = row_start ? (row_ff >= ROW_W'(3)) : (row_ff >= ROW_W'(2));
   assign bot_ok  = row_start ? ((row_ff - ROW_W'(1)) < height_ff) : (row_ff < height_ff);
   assign left_ok = row_start ? (width_ff >= WDIM_W'(2)) : (col_ff >= COL_W'(2));

   assign frame_end = row_start && (row_ff == height_ff + ROW_W'(1));
   assign col_last  = (WDIM_W'(col_ff) + WDIM_W'(1)) >= width_ff;

   assign pix_in = real_px ? rbb_pkg::pixel_type'({req_bus.red_in, req_bus.green_in,
                                                    req_bus.blue_in})
                           : '0;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
      end else if (load1) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (col_last) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   assign v1_in = (v1_ff && !en2) || load1;

   // stage 1 payload
   rbb_pkg::pixel_type pix1_ff;
   logic [COL_W-1:0]   col1_ff;
   logic               emit1_ff, top1_ff, bot1_ff, left1_ff, right1_ff, fe1_ff;

   always_ff @(posedge clock) begin
      if (load1) begin
         pix1_ff   <= pix_in;
         col1_ff   <= col_ff;
         emit1_ff  <= emit;
         top1_ff   <= top_ok;
         bot1_ff   <= bot_ok;
         left1_ff  <= left_ok;
         right1_ff <= mid_row;
         fe1_ff    <= frame_end;
      end
   end

   // ---------------------------------------------------------------
   // Line buffer: entry per column holds the two rows above
   // ---------------------------------------------------------------
   logic              take2;
   rbb_pkg::line_type line_rd;
   rbb_pkg::line_type line_wr;

   assign take2   = v1_ff && en2;
   assign line_wr = '{upper: line_rd.middle, middle: pix1_ff};

   rbb_line_buf #(
      .DEPTH(MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (load1),
      .rd_addr (col_ff),
      .wr_en   (take2),
      .wr_addr (col1_ff),
      .wr_data (line_wr),
      .rd_data (line_rd)
   );

   // ---------------------------------------------------------------
   // Stage 2: window shift and border masking
   // Only two stored columns are needed; the third is the column that
   // arrives with this beat.
   // ---------------------------------------------------------------
   rbb_pkg::pixel_type win1_ff [NROW];
   rbb_pkg::pixel_type win2_ff [NROW];
   rbb_pkg::pixel_type new_col [NROW];
   rbb_pkg::pixel_type tap2_ff [NCOL][NROW];
   rbb_pkg::pixel_type tap2_in [NCOL][NROW];
   logic               col_ok  [NCOL];
   logic               row_ok  [NROW];
   logic               fe2_ff;

   assign new_col[0] = line_rd.upper;
   assign new_col[1] = line_rd.middle;
   assign new_col[2] = pix1_ff;

   assign col_ok[0] = left1_ff;
   assign col_ok[1] = 1'b1;
   assign col_ok[2] = right1_ff;
   assign row_ok[0] = top1_ff;
   assign row_ok[1] = 1'b1;
   assign row_ok[2] = bot1_ff;

   always_comb begin
      for (int k = 0; k < NROW; k++) begin
         tap2_in[0][k] = (col_ok[0] && row_ok[k]) ? win1_ff[k] : '0;
         tap2_in[1][k] = (col_ok[1] && row_ok[k]) ? win2_ff[k] : '0;
         tap2_in[2][k] = (col_ok[2] && row_ok[k]) ? new_col[k] : '0;
      end
   end

   assign v2_in = en2 ? (v1_ff && emit1_ff) : v2_ff;

   always_ff @(posedge clock) begin
      if (take2) begin
         for (int k = 0; k < NROW; k++) begin
            win1_ff[k] <= win2_ff[k];
            win2_ff[k] <= new_col[k];
         end
      end
      if (en2) begin
         tap2_ff <= tap2_in;
         fe2_ff  <= fe1_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: one lane per color channel (sum, then divide by 9)
   // ---------------------------------------------------------------
   rbb_pkg::lane_taps_type red_taps, green_taps, blue_taps;
   logic [rbb_pkg::CHAN_W-1:0] red_avg, green_avg, blue_avg;

   always_comb begin
      for (int i = 0; i < NCOL; i++) begin
         for (int k = 0; k < NROW; k++) begin
            red_taps[i][k]   = tap2_ff[i][k].red;
            green_taps[i][k] = tap2_ff[i][k].green;
            blue_taps[i][k]  = tap2_ff[i][k].blue;
         end
      end
   end

   rbb_lane u_lane_red (
      .clock    (clock),
      .load     (en3),
      .taps     (red_taps),
      .quotient (red_avg)
   );

   rbb_lane u_lane_green (
      .clock    (clock),
      .load     (en3),
      .taps     (green_taps),
      .quotient (green_avg)
   );

   rbb_lane u_lane_blue (
      .clock    (clock),
      .load     (en3),
      .taps     (blue_taps),
      .quotient (blue_avg)
   );

   assign ctl3_in = en3 ? '{valid: v2_ff, frame_end: fe2_ff} : ctl3_ff;

   // ---------------------------------------------------------------
   // Stage 4: merge lanes into the output register
   // ---------------------------------------------------------------
   rbb_pkg::pixel_type avg;

   assign avg = '{red: red_avg, green: green_avg, blue: blue_avg};

   rbb_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl3_ff),
      .avg     (avg),
      .take    (take4),
      .rsp_bus (rsp_bus)
   );

   // ---------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WDIM_W'(RESET_WIDTH);
         height_ff <= ROW_W'(RESET_HEIGHT);
         col_ff    <= '0;
         row_ff    <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         ctl3_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         ctl3_ff   <= ctl3_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rbb_checker.sv =====
`default_nettype none

module rbb_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [rbb_pkg::CHAN_W-1:0]  rsp_red,
   input wire logic [rbb_pkg::CHAN_W-1:0]  rsp_green,
   input wire logic [rbb_pkg::CHAN_W-1:0]  rsp_blue,
   input wire logic                        rsp_frame_end
);

   // stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
                                  && $stable(rsp_blue) && $stable(rsp_frame_end))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_reset_open: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req not ready after reset");

   // req only backs up when an rsp beat is stuck
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("req stalled with output free (valid %0b)", req_valid);

endmodule

bind rgb_box_blur_3x3_top rbb_checker u_rbb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_red       (rsp_bus.red_out),
   .rsp_green     (rsp_bus.green_out),
   .rsp_blue      (rsp_bus.blue_out),
   .rsp_frame_end (rsp_bus.frame_end)
);

`default_nettype wire

// ===== tb/rgb_box_blur_3x3_top_test.sv =====
`default_nettype none

module rgb_box_blur_3x3_top_test;

   // geometry limits, matched to the instance below
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // divisor of the box average: nine neighbors, border taps count as zero
   localparam int NEIGHBORS = 9;

   // cycles allowed after the last expected beat for in-flight work to settle;
   // the pipeline is four stages deep, so this is generous
   localparam int SETTLE_CYCLES = 16;

   // watchdog: cycles in a row without any beat on either channel
   localparam int STALL_LIMIT = 20000;

   // long sink hold-off, repeated every HOLD_EVERY input beats
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_EVERY  = 2500;

   localparam int MAX_REPORTS  = 10;
   localparam int RANDOM_ITEMS = 200;

   typedef struct packed {
      rbb_pkg::kind_type  kind;
      rbb_pkg::pixel_type px;
   } feed_beat_type;

   typedef struct packed {
      logic [rbb_pkg::CHAN_W-1:0] red;
      logic [rbb_pkg::CHAN_W-1:0] green;
      logic [rbb_pkg::CHAN_W-1:0] blue;
      logic                       frame_end;
   } blur_out_type;

   typedef enum logic [1:0] {
      FILL_RANDOM,
      FILL_EXTREME,
      FILL_SATURATE
   } fill_type;

   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_RANDOM,
      SINK_PATTERN,
      SINK_SPARSE
   } sink_mode_type;

   // ---------------------------------------------------------------------------
   // clock, reset, DUT
   // ---------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic                            csr_we    = 1'b0;
   logic [rbb_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [rbb_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   rbb_req_if req_bus ();
   rbb_rsp_if rsp_bus ();

   rgb_box_blur_3x3_top #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // Box filter predictor. Own copy of the geometry registers, the two line
   // buffers, the 3x3 window and the raster counters. Called once per accepted
   // req beat; yields at most one blurred pixel.
   // ---------------------------------------------------------------------------
   logic [rbb_pkg::CSR_DATA_W-1:0] cfg_width  = 11'd640;
   logic [rbb_pkg::CSR_DATA_W-1:0] cfg_height = 11'd480;

   rbb_pkg::pixel_type upper_row  [MAX_WIDTH];
   rbb_pkg::pixel_type middle_row [MAX_WIDTH];
   rbb_pkg::pixel_type taps       [NEIGHBORS];   // column-major: slot*3 + (top/mid/bot)
   int unsigned col_at;
   int unsigned row_at;
   int unsigned out_done;

   // zero reads as one, anything above the limit is clamped
   function automatic int unsigned fit_dim(input logic [rbb_pkg::CSR_DATA_W-1:0] v,
                                           input int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void add_tap_column(input int slot, input bit top_ok, input bit bot_ok,
                                          inout int unsigned sum_r, sum_g, sum_b);
      int k;
      rbb_pkg::pixel_type px;
      for (k = 0; k < 3; k++) begin
         if (k == 0 && !top_ok) continue;
         if (k == 2 && !bot_ok) continue;
         px = taps[slot * 3 + k];
         sum_r += px.red;
         sum_g += px.green;
         sum_b += px.blue;
      end
   endfunction

   function automatic void blur_step(input rbb_pkg::kind_type kind,
                                     input rbb_pkg::pixel_type px_in,
                                     output bit emitted, output blur_out_type res);
      int unsigned w, h, total, r, c, n;
      int unsigned sum_r, sum_g, sum_b;
      int i;
      bit in_frame, primed, top_ok, bot_ok;
      rbb_pkg::pixel_type px;
      w        = fit_dim(cfg_width, MAX_WIDTH);
      h        = fit_dim(cfg_height, MAX_HEIGHT);
      total    = w * h;
      r        = row_at;
      c        = col_at;
      n        = r * w + c;
      in_frame = n < total;
      primed   = n >= w + 1;
      emitted  = 1'b0;
      res      = '0;
      sum_r    = 0;
      sum_g    = 0;
      sum_b    = 0;

      // flush while pixels of the frame are still due: dropped, no state change
      if (kind == rbb_pkg::KIND_FLUSH && in_frame) return;
      // past the last pixel a pixel beat only drains, its value is dropped
      px = in_frame ? px_in : '0;

      // row start: finish the last pixel of the row before
      if (c == 0 && primed) begin
         top_ok = r >= 3;
         bot_ok = (r - 1) < h;
         if (w >= 2) add_tap_column(1, top_ok, bot_ok, sum_r, sum_g, sum_b);
         add_tap_column(2, top_ok, bot_ok, sum_r, sum_g, sum_b);
         emitted = 1'b1;
      end

      for (i = 0; i < 6; i++) taps[i] = taps[i + 3];
      taps[6]       = upper_row[c];
      taps[7]       = middle_row[c];
      taps[8]       = px;
      upper_row[c]  = middle_row[c];
      middle_row[c] = px;

      // mid-row: pixel one row up, one column left
      if (c >= 1 && primed) begin
         top_ok = r >= 2;
         bot_ok = r < h;
         if (c >= 2) add_tap_column(0, top_ok, bot_ok, sum_r, sum_g, sum_b);
         add_tap_column(1, top_ok, bot_ok, sum_r, sum_g, sum_b);
         add_tap_column(2, top_ok, bot_ok, sum_r, sum_g, sum_b);
         emitted = 1'b1;
      end

      c++;
      if (c >= w) begin
         c = 0;
         r++;
      end
      col_at = c;
      row_at = r;

      if (!emitted) return;

      res.red   = rbb_pkg::CHAN_W'(sum_r / NEIGHBORS);
      res.green = rbb_pkg::CHAN_W'(sum_g / NEIGHBORS);
      res.blue  = rbb_pkg::CHAN_W'(sum_b / NEIGHBORS);
      // frame wrap: counters go back to zero with the frame_end beat
      if (out_done + 1 >= total) begin
         res.frame_end = 1'b1;
         col_at        = 0;
         row_at        = 0;
         out_done      = 0;
      end else begin
         out_done++;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Queues and counters
   // ---------------------------------------------------------------------------
   feed_beat_type feed_q    [$];   // req beats not yet taken by the DUT
   blur_out_type  blurred_q [$];   // blurred pixels still owed by the DUT

   bit          req_fire;          // req beat taken at the last rising edge
   int unsigned beats_in;
   int unsigned rsp_count;
   int unsigned mismatches;
   int unsigned idle_cycles;
   int unsigned stim_items;

   // ---------------------------------------------------------------------------
   // Monitor: predicts on every req beat, checks every rsp beat. Prediction
   // runs first, though a result never leaves in the cycle its pixel enters.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : beat_monitor
      bit           made;
      blur_out_type want;
      blur_out_type got;
      req_fire = 1'b0;
      if (!reset && req_bus.valid && req_bus.ready) begin
         req_fire = 1'b1;
         beats_in++;
         blur_step(rbb_pkg::kind_type'(req_bus.kind),
                   {req_bus.red_in, req_bus.green_in, req_bus.blue_in}, made, want);
         if (made) blurred_q.push_back(want);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.red_out, rsp_bus.green_out, rsp_bus.blue_out, rsp_bus.frame_end};
         if (blurred_q.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("rsp beat %0d with nothing expected: r=%0d g=%0d b=%0d end=%0b",
                        rsp_count, got.red, got.green, got.blue, got.frame_end);
            mismatches++;
         end else begin
            want = blurred_q.pop_front();
            if (got !== want) begin
               if (mismatches < MAX_REPORTS)
                  $display("rsp beat %0d: want %0d/%0d/%0d end %0b, got %0d/%0d/%0d end %0b",
                           rsp_count, want.red, want.green, want.blue, want.frame_end,
                           got.red, got.green, got.blue, got.frame_end);
               mismatches++;
            end
         end
         rsp_count++;
      end
   end

   // ---------------------------------------------------------------------------
   // Driver: offers the head of feed_q in bursts of random length, with random
   // gaps; now and then a long burst with no gaps. A beat once offered stays
   // valid until taken.
   // ---------------------------------------------------------------------------
   int unsigned burst_left = 8;
   int unsigned gap_left   = 0;

   always @(negedge clock) begin : req_source
      feed_beat_type head;
      if (req_fire) begin
         void'(feed_q.pop_front());
         if (burst_left != 0) burst_left--;
         if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
               burst_left = $urandom_range(64, 200);
               gap_left   = 0;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
            end
         end
      end
      if (reset || gap_left != 0 || feed_q.size() == 0) begin
         if (gap_left != 0) gap_left--;
         req_bus.valid <= 1'b0;
      end else begin
         head = feed_q[0];
         req_bus.valid    <= 1'b1;
         req_bus.kind     <= head.kind;
         req_bus.red_in   <= head.px.red;
         req_bus.green_in <= head.px.green;
         req_bus.blue_in  <= head.px.blue;
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: ready follows a mode picked anew at random (always open, coin
   // flip, fixed 3-of-5 pattern, mostly stalled). Every HOLD_EVERY input beats
   // it closes for HOLD_CYCLES while the driver keeps offering, so the pipeline
   // fills and req ready must drop.
   // ---------------------------------------------------------------------------
   sink_mode_type sink_mode     = SINK_OPEN;
   int unsigned   mode_left     = 0;
   int unsigned   pattern_phase = 0;
   int unsigned   hold_left     = 0;
   int unsigned   next_hold_at  = 300;

   always @(negedge clock) begin : rsp_sink
      bit take;
      if (hold_left != 0) begin
         hold_left--;
         take = 1'b0;
      end else if (!reset && beats_in >= next_hold_at) begin
         hold_left    = HOLD_CYCLES;
         next_hold_at = next_hold_at + HOLD_EVERY;
         take         = 1'b0;
      end else begin
         if (mode_left == 0) begin
            sink_mode = sink_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 256);
         end else begin
            mode_left--;
         end
         pattern_phase++;
         case (sink_mode)
            SINK_OPEN:    take = 1'b1;
            SINK_RANDOM:  take = $urandom_range(0, 1);
            SINK_PATTERN: take = (pattern_phase % 5) < 3;
            default:      take = ($urandom_range(0, 5) == 0);
         endcase
      end
      rsp_bus.ready <= take;
   end

   // ---------------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat in %0d cycles, %0d results outstanding",
                  STALL_LIMIT, blurred_q.size());
         $display("rgb_box_blur_3x3_top_test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic push_beat(input rbb_pkg::kind_type kind, input rbb_pkg::pixel_type px);
      feed_beat_type b;
      b.kind = kind;
      b.px   = px;
      feed_q.push_back(b);
   endtask

   function automatic rbb_pkg::pixel_type pick_pixel(input fill_type fill);
      rbb_pkg::pixel_type px;
      px = 24'($urandom);
      case (fill)
         FILL_EXTREME: begin
            px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         FILL_SATURATE: if ($urandom_range(0, 3) != 0) px = '1;
         default: ;
      endcase
      return px;
   endfunction

   // One frame at the current geometry: w*h pixels then w+1 drain beats, each
   // drain a flush or a pixel at random. Stray flushes inside the frame are
   // noise and not counted. A cut frame stops partway and sends no drain.
   task automatic queue_frame(input bit cut);
      int unsigned w, h, n_px, i;
      fill_type fill;
      w    = fit_dim(cfg_width, MAX_WIDTH);
      h    = fit_dim(cfg_height, MAX_HEIGHT);
      n_px = cut ? $urandom_range(0, w * h - 1) : w * h;
      fill = fill_type'($urandom_range(0, 2));
      for (i = 0; i < n_px; i++) begin
         if ($urandom_range(0, 19) == 0)
            push_beat(rbb_pkg::KIND_FLUSH, rbb_pkg::pixel_type'(24'($urandom)));
         push_beat(rbb_pkg::KIND_PIXEL, pick_pixel(fill));
      end
      stim_items += n_px;
      if (!cut) begin
         for (i = 0; i <= w; i++) begin
            if ($urandom_range(0, 1))
               push_beat(rbb_pkg::KIND_FLUSH, rbb_pkg::pixel_type'(24'($urandom)));
            else
               push_beat(rbb_pkg::KIND_PIXEL, pick_pixel(FILL_RANDOM));
         end
         stim_items += w + 1;
      end
   endtask

   // everything sent, everything owed received, pipeline settled
   task automatic wait_idle();
      while (feed_q.size() != 0 || req_bus.valid || blurred_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write; any write restarts the frame on both sides
   task automatic write_csr(input logic [rbb_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [rbb_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == rbb_pkg::CSR_IMAGE_WIDTH) cfg_width = val;
      else cfg_height = val;
      col_at   = 0;
      row_at   = 0;
      out_done = 0;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin : sequencer
      int i, frames, f, pick;
      int unsigned random_base;
      logic [rbb_pkg::CSR_DATA_W-1:0] w_val, h_val;

      req_bus.valid    = 1'b0;
      req_bus.kind     = rbb_pkg::KIND_PIXEL;
      req_bus.red_in   = '0;
      req_bus.green_in = '0;
      req_bus.blue_in  = '0;
      rsp_bus.ready    = 1'b0;
      for (i = 0; i < MAX_WIDTH; i++) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end
      for (i = 0; i < NEIGHBORS; i++) taps[i] = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait_idle();

      // directed: 3x3 of full white (center hits the largest sum), a flush in
      // mid-frame that must be dropped, a pixel among the drain beats
      write_csr(rbb_pkg::CSR_IMAGE_WIDTH, 11'd3);
      write_csr(rbb_pkg::CSR_IMAGE_HEIGHT, 11'd3);
      for (i = 0; i < 9; i++) begin
         if (i == 4) push_beat(rbb_pkg::KIND_FLUSH, '0);
         push_beat(rbb_pkg::KIND_PIXEL, '1);
      end
      push_beat(rbb_pkg::KIND_FLUSH, '0);
      push_beat(rbb_pkg::KIND_PIXEL, 24'h5A_A5_3C);
      push_beat(rbb_pkg::KIND_FLUSH, '1);
      push_beat(rbb_pkg::KIND_FLUSH, '0);
      wait_idle();

      // directed: zero geometry reads as 1x1; two single-pixel frames back to
      // back, a flush between them lands in the new frame and is dropped
      write_csr(rbb_pkg::CSR_IMAGE_WIDTH, 11'd0);
      write_csr(rbb_pkg::CSR_IMAGE_HEIGHT, 11'd0);
      push_beat(rbb_pkg::KIND_PIXEL, {8'h00, 8'hFF, 8'h80});
      push_beat(rbb_pkg::KIND_PIXEL, '1);
      push_beat(rbb_pkg::KIND_FLUSH, '0);
      push_beat(rbb_pkg::KIND_FLUSH, '0);
      push_beat(rbb_pkg::KIND_PIXEL, {8'hFF, 8'h08, 8'h09});
      push_beat(rbb_pkg::KIND_FLUSH, '0);
      push_beat(rbb_pkg::KIND_FLUSH, '0);
      wait_idle();

      // geometry extreme: one-pixel-wide column with the height clamped
      write_csr(rbb_pkg::CSR_IMAGE_WIDTH, 11'd1);
      write_csr(rbb_pkg::CSR_IMAGE_HEIGHT, 11'd2047);
      queue_frame(1'b0);
      wait_idle();

      // random: mostly small frames, a few wider ones, now and then a zero
      // register; one to three frames per setting, the last sometimes cut
      random_base = stim_items;
      while (stim_items - random_base < RANDOM_ITEMS) begin
         w_val = $urandom_range(1, 10);
         h_val = $urandom_range(1, 6);
         if ($urandom_range(0, 7) == 0) begin
            w_val = $urandom_range(11, 64);
            h_val = $urandom_range(1, 3);
         end
         if ($urandom_range(0, 15) == 0) w_val = '0;
         if ($urandom_range(0, 15) == 0) h_val = '0;
         pick = $urandom_range(0, 3);
         if (pick != 1) write_csr(rbb_pkg::CSR_IMAGE_WIDTH, w_val);
         if (pick != 0) write_csr(rbb_pkg::CSR_IMAGE_HEIGHT, h_val);
         frames = $urandom_range(1, 3);
         for (f = 0; f < frames; f++)
            queue_frame(f == frames - 1 && $urandom_range(0, 9) == 0);
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("rgb_box_blur_3x3_top_test passed");
      end else begin
         $display("rgb_box_blur_3x3_top_test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
